>>> rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character mapping for the integer-to-ASCII formatter.
package itoa_pkg;

  localparam int unsigned NUM_CELLS  = 16;  // one cell per hex digit of a 64-bit value
  localparam int unsigned DEC_BITS   = 32;  // width of the decimal formats
  localparam int unsigned CNT_W      = 5;   // character count / digit count width
  localparam int unsigned BIT_CNT_W  = 5;   // counts DEC_BITS shift steps

  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_X     = 7'h78;
  localparam logic [6:0] CHAR_LOW_A = 7'h61;
  localparam logic [6:0] CHAR_UP_A  = 7'h41;

  typedef enum logic [2:0] {
    OP_SDEC32 = 3'd0,
    OP_UDEC32 = 3'd1,
    OP_HEX32  = 3'd2,
    OP_HEX64  = 3'd3,
    OP_PTR    = 3'd4
  } itoa_op_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DABBLE = 5'b00010,
    ST_SKIP   = 5'b00100,
    ST_PREFIX = 5'b01000,
    ST_DIGITS = 5'b10000
  } itoa_state_e;

  // Per-cycle command broadcast to every digit cell; load wins over dabble, dabble over shift.
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
  } itoa_cell_ctrl_t;

  function automatic logic [6:0] digit_to_ascii(input logic [3:0] digit, input logic upper);
    logic [6:0] d7;
    d7 = {3'b000, digit};
    if (digit < 4'd10) begin
      return CHAR_ZERO + d7;
    end else if (upper) begin
      return CHAR_UP_A + d7 - 7'd10;
    end else begin
      return CHAR_LOW_A + d7 - 7'd10;
    end
  endfunction

endpackage

>>> rtl/itoa_digit_cell.sv
`timescale 1ns / 1ps
// One digit cell: holds a nibble, runs a double-dabble step or passes its digit upward.
module itoa_digit_cell (
  input  logic                      clk_i,
  input  itoa_pkg::itoa_cell_ctrl_t ctrl_i,
  input  logic [3:0]                load_digit_i,
  input  logic                      carry_i,
  input  logic [3:0]                digit_i,
  output logic [3:0]                digit_o,
  output logic                      carry_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Add 3 before the shift so the BCD digit carries at ten.
  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.load) begin
      digit_d = load_digit_i;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], carry_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

>>> rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// Integer-to-ASCII formatter: a row of sixteen digit cells with a small sequencer in front.
//
// Each input transaction is one number; it comes out as one output transaction per ASCII
// character, most significant first, tlast on the final one with the character count. The
// decimal formats run the value through the cell row with double dabble, one bit per cycle
// for all 32 bits; hex formats load the cells directly. Leading zero digits are then shifted
// out of the top cell at one per cycle (at most 15), and the characters follow, held while
// the output is stalled. Operation codes 5 to 7 are accepted and give no output. A new
// number is accepted once the last character sits in the output register.
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] value
  input  logic [3:0]  s_axis_tuser,   // [2:0] operation, [3] upper_case
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] character, [11:7] char_count, [15:12] zero
  output logic        m_axis_tlast
);

  localparam int unsigned NC = itoa_pkg::NUM_CELLS;
  localparam int unsigned CW = itoa_pkg::CNT_W;

  itoa_pkg::itoa_state_e state_q, state_d;
  itoa_pkg::itoa_cell_ctrl_t cell_ctrl;

  logic [itoa_pkg::DEC_BITS-1:0]  bin_q, bin_d;
  logic [itoa_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] total_q, total_d;
  logic [1:0]    pre_cnt_q, pre_cnt_d;
  logic          neg_q, neg_d;
  logic          upper_q, upper_d;

  logic [6:0]    out_char_q, out_char_d;
  logic [CW-1:0] out_cnt_q, out_cnt_d;
  logic          out_last_q, out_last_d;
  logic          out_valid_q, out_valid_d;

  logic [3:0] cell_digit [NC];
  logic       cell_carry [NC];
  logic [63:0] load_val;

  logic          in_acc, op_valid, op_dec, out_free, emit, skip_now;
  logic [2:0]    op_raw;
  logic          upper_in;
  logic [31:0]   lo;
  logic [3:0]    top_digit;

  assign op_raw   = s_axis_tuser[2:0];
  assign upper_in = s_axis_tuser[3];
  assign lo       = s_axis_tdata[31:0];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign op_valid = (op_raw == itoa_pkg::OP_SDEC32) || (op_raw == itoa_pkg::OP_UDEC32) ||
                    (op_raw == itoa_pkg::OP_HEX32)  || (op_raw == itoa_pkg::OP_HEX64)  ||
                    (op_raw == itoa_pkg::OP_PTR);
  assign op_dec   = (op_raw == itoa_pkg::OP_SDEC32) || (op_raw == itoa_pkg::OP_UDEC32);
  assign out_free = !out_valid_q || m_axis_tready;
  assign top_digit = cell_digit[NC-1];
  assign skip_now  = (top_digit == 4'd0) && (rem_q > CW'(1));

  assign s_axis_tready = (state_q == itoa_pkg::ST_IDLE);

  // Decimal formats start from cleared cells; hex32 drops the upper word.
  always_comb begin
    if (op_dec) begin
      load_val = '0;
    end else if (op_raw == itoa_pkg::OP_HEX32) begin
      load_val = {32'd0, lo};
    end else begin
      load_val = s_axis_tdata;
    end
  end

  always_comb begin
    cell_ctrl.load   = in_acc && op_valid;
    cell_ctrl.dabble = (state_q == itoa_pkg::ST_DABBLE);
    cell_ctrl.shift  = ((state_q == itoa_pkg::ST_SKIP) && skip_now) ||
                       ((state_q == itoa_pkg::ST_DIGITS) && out_free);
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic       nbr_carry;
    logic [3:0] nbr_digit;
    if (i == 0) begin : g_first
      assign nbr_carry = bin_q[itoa_pkg::DEC_BITS-1];
      assign nbr_digit = 4'd0;
    end else begin : g_rest
      assign nbr_carry = cell_carry[i-1];
      assign nbr_digit = cell_digit[i-1];
    end
    itoa_digit_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .load_digit_i (load_val[4*i +: 4]),
      .carry_i      (nbr_carry),
      .digit_i      (nbr_digit),
      .digit_o      (cell_digit[i]),
      .carry_o      (cell_carry[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bit_cnt_d   = bit_cnt_q;
    rem_d       = rem_q;
    total_d     = total_q;
    pre_cnt_d   = pre_cnt_q;
    neg_d       = neg_q;
    upper_d     = upper_q;
    emit        = 1'b0;
    out_char_d  = out_char_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_acc && op_valid) begin
          rem_d     = CW'(NC);
          bit_cnt_d = '1;
          neg_d     = (op_raw == itoa_pkg::OP_SDEC32) && lo[31];
          upper_d   = upper_in &&
                      ((op_raw == itoa_pkg::OP_HEX32) || (op_raw == itoa_pkg::OP_HEX64));
          bin_d     = ((op_raw == itoa_pkg::OP_SDEC32) && lo[31]) ? (~lo + 32'd1) : lo;
          if ((op_raw == itoa_pkg::OP_SDEC32) && lo[31]) begin
            pre_cnt_d = 2'd1;
          end else if (op_raw == itoa_pkg::OP_PTR) begin
            pre_cnt_d = 2'd2;
          end else begin
            pre_cnt_d = 2'd0;
          end
          state_d = op_dec ? itoa_pkg::ST_DABBLE : itoa_pkg::ST_SKIP;
        end
      end
      itoa_pkg::ST_DABBLE: begin
        bin_d     = {bin_q[itoa_pkg::DEC_BITS-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = itoa_pkg::ST_SKIP;
        end
      end
      itoa_pkg::ST_SKIP: begin
        if (skip_now) begin
          rem_d = rem_q - 1'b1;
        end else begin
          total_d = CW'(pre_cnt_q) + rem_q;
          state_d = (pre_cnt_q != 2'd0) ? itoa_pkg::ST_PREFIX : itoa_pkg::ST_DIGITS;
        end
      end
      itoa_pkg::ST_PREFIX: begin
        if (out_free) begin
          emit       = 1'b1;
          out_last_d = 1'b0;
          out_cnt_d  = '0;
          if (neg_q) begin
            out_char_d = itoa_pkg::CHAR_MINUS;
          end else if (pre_cnt_q == 2'd2) begin
            out_char_d = itoa_pkg::CHAR_ZERO;
          end else begin
            out_char_d = itoa_pkg::CHAR_X;
          end
          pre_cnt_d = pre_cnt_q - 1'b1;
          if (pre_cnt_q == 2'd1) begin
            state_d = itoa_pkg::ST_DIGITS;
          end
        end
      end
      itoa_pkg::ST_DIGITS: begin
        if (out_free) begin
          emit       = 1'b1;
          out_char_d = itoa_pkg::digit_to_ascii(top_digit, upper_q);
          rem_d      = rem_q - 1'b1;
          if (rem_q == CW'(1)) begin
            out_last_d = 1'b1;
            out_cnt_d  = total_q;
            state_d    = itoa_pkg::ST_IDLE;
          end else begin
            out_last_d = 1'b0;
            out_cnt_d  = '0;
          end
        end
      end
      default: begin
        state_d = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bit_cnt_q  <= bit_cnt_d;
    rem_q      <= rem_d;
    total_q    <= total_d;
    pre_cnt_q  <= pre_cnt_d;
    neg_q      <= neg_d;
    upper_q    <= upper_d;
    out_char_q <= out_char_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'd0, out_cnt_q, out_char_q};

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register lost its one-hot code");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itoa_pkg::ST_DIGITS) |-> (rem_q != '0) && (rem_q <= CW'(NC)))
    else $error("digit count out of range while emitting");

  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (out_cnt_q != '0)))
    else $error("character count does not match last marker");

  a_bad_op_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !op_valid) |=> (state_q == itoa_pkg::ST_IDLE))
    else $error("unused operation code started a conversion");

endmodule
